>>> hw/rtl/olst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list store package
// Item types, command and status codes, sequencer states and defaults used
// by the ordered list store.
// ----------------------------------------------------------------------------
package olst_pkg;

	localparam int unsigned DEF_CAPACITY  = 64;
	localparam int unsigned DEF_TAG_WIDTH = 32;

	localparam int unsigned INDEX_W = 6;
	localparam int unsigned TAG_W   = 32;
	localparam int unsigned POS_W   = 6;
	localparam int unsigned COUNT_W = 7;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_GET    = 2'd1,
		CMD_FIND   = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_RANGE    = 2'd1,
		STS_NOTFOUND = 2'd2,
		STS_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GET,
		ST_FIND,
		ST_SHIFT,
		ST_RESP
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [INDEX_W-1:0] index;
		logic [TAG_W-1:0]   tag_in;
	} cmd_item_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag_out;
		logic [POS_W-1:0]   found_pos;
		status_t            status;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
	} rsp_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/olst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module olst_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/ordered_list_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list store
// Bounded ordered list of tags with append, get, find and remove-at commands.
// ----------------------------------------------------------------------------
// The list lives in a single-port-read RAM of CAPACITY entries, and one small
// sequencer walks it one entry per cycle. A command item is taken only while
// the sequencer is idle; its result is registered and may wait on rsp_ready
// while the next item is already accepted. Append, removal of the last entry
// and any error or empty-list case go straight to the result; get reads the
// indexed entry once, find does one RAM read per scanned entry, ending at the
// first match, and remove moves each later entry down by one RAM read and one
// RAM write per cycle. The block is ready for the next item as soon as the
// result is loaded into the output register; a result still waiting on
// rsp_ready holds the next one back in the sequencer. The RAM needs no
// clearing after reset, since only entries below the count are ever used.
module ordered_list_store #(
	parameter int unsigned CAPACITY  = olst_pkg::DEF_CAPACITY,
	parameter int unsigned TAG_WIDTH = olst_pkg::DEF_TAG_WIDTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_ready,
	input  wire olst_pkg::cmd_item_t cmd_item,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output olst_pkg::rsp_item_t      rsp_item
);

	import olst_pkg::*;

	localparam int unsigned AW  = $clog2(CAPACITY);
	localparam int unsigned CW  = $clog2(CAPACITY + 1);
	localparam int unsigned IXW = (CW > INDEX_W) ? CW : INDEX_W;

	state_t               state_q, state_d;
	logic [CW-1:0]        count_q, count_d;
	logic [AW-1:0]        ptr_q, ptr_d;
	logic [TAG_WIDTH-1:0] tag_q, tag_d;
	rsp_item_t            res_q, res_d;
	rsp_item_t            rsp_q;
	rsp_item_t            rsp_next;
	logic                 rsp_valid_q;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [TAG_WIDTH-1:0] wr_data;
	logic [AW-1:0]        rd_addr;
	logic [TAG_WIDTH-1:0] rd_data;

	logic                 accept;
	logic [IXW-1:0]       idx_x;
	logic [IXW-1:0]       cnt_x;
	logic                 idx_ok;
	logic                 idx_last;
	logic [63:0]          tag_wide;
	logic [TAG_WIDTH-1:0] tag_in_m;
	logic [63:0]          rd_wide;
	logic                 ptr_more;
	logic                 rsp_load;

	olst_ram #(
		.WIDTH(TAG_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;

	assign idx_x    = IXW'(cmd_item.index);
	assign cnt_x    = IXW'(count_q);
	assign idx_ok   = idx_x < cnt_x;
	// Only meaningful when the index is in range, so the add cannot wrap.
	assign idx_last = (idx_x + IXW'(1)) >= cnt_x;

	assign tag_wide = 64'(cmd_item.tag_in);
	assign tag_in_m = tag_wide[TAG_WIDTH-1:0];
	assign rd_wide  = 64'(rd_data);

	// The entry after the one whose data is on the read port is still in the list.
	assign ptr_more = (CW'(ptr_q) + CW'(1)) < count_q;

	assign rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		rsp_next          = res_q;
		rsp_next.count    = COUNT_W'(count_q);
		rsp_next.is_empty = (count_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		tag_q <= tag_d;
		res_q <= res_d;
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		ptr_d   = ptr_q;
		tag_d   = tag_q;
		res_d   = res_q;
		wr_en   = 1'b0;
		wr_addr = ptr_q - AW'(1);
		wr_data = rd_data;
		rd_addr = ptr_q + AW'(1);

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tag_d           = tag_in_m;
					res_d.tag_out   = '0;
					res_d.found_pos = '0;
					res_d.status    = STS_OK;
					res_d.count     = '0;
					res_d.is_empty  = 1'b0;
					state_d         = ST_RESP;
					unique case (cmd_item.cmd)
						CMD_APPEND: begin
							if (count_q == CW'(CAPACITY)) begin
								res_d.status = STS_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = AW'(count_q);
								wr_data = tag_in_m;
								count_d = count_q + CW'(1);
							end
						end
						CMD_GET: begin
							if (idx_ok) begin
								rd_addr = AW'(cmd_item.index);
								state_d = ST_GET;
							end else begin
								res_d.status = STS_RANGE;
							end
						end
						CMD_FIND: begin
							if (count_q == '0) begin
								res_d.status = STS_NOTFOUND;
							end else begin
								rd_addr = '0;
								ptr_d   = '0;
								state_d = ST_FIND;
							end
						end
						CMD_REMOVE: begin
							if (!idx_ok) begin
								res_d.status = STS_RANGE;
							end else if (idx_last) begin
								count_d = count_q - CW'(1);
							end else begin
								rd_addr = AW'(cmd_item.index) + AW'(1);
								ptr_d   = AW'(cmd_item.index) + AW'(1);
								state_d = ST_SHIFT;
							end
						end
						default: begin
							res_d.status = STS_RANGE;
						end
					endcase
				end
			end
			ST_GET: begin
				res_d.tag_out = rd_wide[TAG_W-1:0];
				state_d       = ST_RESP;
			end
			ST_FIND: begin
				if (rd_data == tag_q) begin
					res_d.found_pos = POS_W'(ptr_q);
					res_d.status    = STS_OK;
					state_d         = ST_RESP;
				end else if (!ptr_more) begin
					res_d.status = STS_NOTFOUND;
					state_d      = ST_RESP;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			ST_SHIFT: begin
				// Move the entry just read down one place while the next one is fetched.
				wr_en = 1'b1;
				if (ptr_more) begin
					ptr_d = ptr_q + AW'(1);
				end else begin
					count_d = count_q - CW'(1);
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_walk_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND || state_q == ST_SHIFT) |-> (CW'(ptr_q) < count_q))
		else $error("scan or shift pointer left the list");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_item.cmd == CMD_APPEND && count_q != CW'(CAPACITY))
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("append did not grow the list by one");

	a_shift_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (wr_en && wr_addr == ptr_q - AW'(1)))
		else $error("shift step without a write one place down");

	a_rsp_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_RESP))
		else $error("result appeared without the sequencer finishing an item");

endmodule
`default_nettype wire
